// ----- design/mmh_pkg.sv -----
// Shared types, constants and helpers for the MurmurHash2 key hasher.
// Depends on nothing; every other file in this block imports it.
package mmh_pkg;

  // Hash constants
  localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
  localparam logic [31:0] SEED_INIT   = 32'h9e3779b9;
  localparam int unsigned WORD_SHIFT  = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  // Bytes in one key word and its full count code
  localparam logic [2:0]  FULL_COUNT  = 3'd4;

  // Queue sizes (powers of two)
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned CMDQ_AW     = $clog2(CMDQ_DEPTH);
  localparam int unsigned RESQ_DEPTH  = 2;
  localparam int unsigned RESQ_AW     = $clog2(RESQ_DEPTH);

  // Input item as seen on the push side
  typedef struct packed {
    logic [31:0] key_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic [31:0] key_length;
  } in_item_t;

  // Result item as seen on the pop side
  typedef struct packed {
    logic [31:0] key_hash;
    logic        bad_framing;
  } out_item_t;

  // What the back end does with the running hash for one word
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,  // nothing folded (empty last word or short word)
    OP_FULL = 2'd1,  // h = h*M ^ kmix
    OP_TAIL = 2'd2   // h = (h ^ tail)*M
  } cmd_op_t;

  // One command from the front end to the back end
  typedef struct packed {
    cmd_op_t     op;
    logic        first;   // start of key: running hash restarts at init
    logic [31:0] init;    // seed ^ key_length
    logic [31:0] opnd;    // mixed word for OP_FULL, masked tail for OP_TAIL
    logic        last;    // finalize and emit after this command
    logic        bad;     // framing verdict, valid with last
  } cmd_t;

  // Command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_stat_t;

  // Mask of the valid low bytes of a partial word
  function automatic logic [31:0] tail_mask(logic [2:0] cnt);
    logic [31:0] m;
    unique case (cnt)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ----- design/murmur2_key_hash.sv -----
// Top level of the streaming MurmurHash2 key hasher.
// Depends on mmh_pkg, mmh_front, mmh_cmd_fifo and mmh_back.
//
// Hashes byte keys sent as little-endian 32-bit words with 32-bit MurmurHash2
// and hands one result (hash plus framing flag) per key on a queue-style pop
// side. The push side takes one word per cycle while the command queue has
// room; in the back end each full, partial or empty word is one fold step and
// the last word of a key adds a finalize multiply on the single shared
// multiplier, so a stream of long keys runs near one word per cycle. With
// nothing stalled, the last word of a key passes stage one, the command queue
// and the running hash register, then the finalize step into the result queue.
// The user must write the seed through cfg_hash_seed (always ready) only while
// no key is in flight; the block itself does not enforce this.
module murmur2_key_hash
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_hash_seed
);

  logic       cmd_push, cmd_pop;
  cmd_t       cmd_wr, cmd_rd;
  cmdq_stat_t cmdq_stat;

  mmh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_hash_seed (cfg_hash_seed),
    .cmd_push      (cmd_push),
    .cmd           (cmd_wr),
    .cmdq_stat     (cmdq_stat)
  );

  mmh_cmd_fifo u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_wr),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_rd),
    .stat   (cmdq_stat)
  );

  mmh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_rd),
    .cmdq_stat (cmdq_stat),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

`ifndef SYNTH
  // Reset leaves no result waiting and the push side open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("result or stall left after reset");

  // Front end never writes a full command queue
  a_no_cmd_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmdq_stat.full)
    else $error("command written into a full queue");

  // Back end never takes from an empty command queue
  a_no_cmd_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmdq_stat.empty)
    else $error("command read from an empty queue");
`endif

endmodule

// ----- design/mmh_front.sv -----
// Front end: takes key words, tracks framing, pre-mixes full words.
// Depends on mmh_pkg; feeds mmh_cmd_fifo.
module mmh_front
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  // seed register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_hash_seed,
  // command output
  output logic        cmd_push,
  output cmd_t        cmd,
  input  cmdq_stat_t  cmdq_stat
);

  // Seed register
  logic [31:0] seed_r;

  // Per-key framing state
  logic        inside_key_r;
  logic [31:0] bytes_seen_r;
  logic [31:0] held_len_r;
  logic        err_r;

  // Stage one: classified item, first multiply done
  logic        s1_v_r,  s1_v_nxt;
  cmd_t        s1_r;

  logic        accept;
  logic        first;
  logic        over;
  logic [2:0]  cnt;
  logic [31:0] base_bytes, bytes_nxt, held_nxt;
  logic        err_nxt;
  cmd_op_t     op;
  logic [31:0] k1_mix;
  logic [31:0] k2_mix;

  assign cfg_ready = 1'b1;
  assign full      = s1_v_r && cmdq_stat.full;
  assign accept    = push && !full;
  assign cmd_push  = s1_v_r && !cmdq_stat.full;

  // Classify the incoming word
  always_comb begin
    first      = !inside_key_r;
    over       = in_item.byte_count > FULL_COUNT;
    cnt        = over ? FULL_COUNT : in_item.byte_count;
    base_bytes = first ? 32'd0 : bytes_seen_r;
    held_nxt   = first ? in_item.key_length : held_len_r;
    bytes_nxt  = base_bytes + 32'(cnt);
    err_nxt    = (!first && err_r) || over ||
                 ((cnt != FULL_COUNT) && !in_item.last_word);
    priority if (cnt == FULL_COUNT) begin
      op = OP_FULL;
    end else if (in_item.last_word && (cnt != 3'd0)) begin
      op = OP_TAIL;
    end else begin
      op = OP_NONE;
    end
    k1_mix = in_item.key_word * MIX_MULT;
  end

  // Second half of the word mix on the way into the queue
  always_comb begin
    k2_mix = (s1_r.opnd ^ (s1_r.opnd >> WORD_SHIFT)) * MIX_MULT;
    cmd    = s1_r;
    if (s1_r.op == OP_FULL) begin
      cmd.opnd = k2_mix;
    end
  end

  assign s1_v_nxt = accept || (s1_v_r && !cmd_push);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= SEED_INIT;
      inside_key_r <= 1'b0;
      err_r        <= 1'b0;
      s1_v_r       <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_hash_seed;
      end
      if (accept) begin
        inside_key_r <= !in_item.last_word;
        err_r        <= err_nxt;
      end
    end
  end

  // Payload of stage one and the key counters
  always_ff @(posedge clk) begin
    if (accept) begin
      bytes_seen_r <= bytes_nxt;
      held_len_r   <= held_nxt;
      s1_r.op      <= op;
      s1_r.first   <= first;
      s1_r.init    <= seed_r ^ in_item.key_length;
      s1_r.opnd    <= (op == OP_FULL) ? k1_mix
                                      : (in_item.key_word & tail_mask(cnt));
      s1_r.last    <= in_item.last_word;
      s1_r.bad     <= err_nxt || (bytes_nxt != held_nxt);
    end
  end

endmodule

// ----- design/mmh_cmd_fifo.sv -----
// Short command queue between the front and back ends.
// Depends on mmh_pkg for cmd_t and the queue depth.
module mmh_cmd_fifo
  import mmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cmd_t       wr_cmd,
  input  logic       rd_en,
  output cmd_t       rd_cmd,
  output cmdq_stat_t stat
);

  cmd_t                 mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wptr_r, rptr_r;
  logic [CMDQ_AW:0]     cnt_r,  cnt_nxt;
  logic                 do_wr,  do_rd;

  assign stat.full  = cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_cmd     = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

// ----- design/mmh_back.sv -----
// Back end: folds commands into the running hash, finalizes, queues results.
// Depends on mmh_pkg; reads mmh_cmd_fifo.
module mmh_back
  import mmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // command input
  input  cmd_t       cmd,
  input  cmdq_stat_t cmdq_stat,
  output logic       cmd_pop,
  // result output
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item
);

  typedef enum logic [1:0] {
    ST_EXEC = 2'b01,
    ST_FIN  = 2'b10
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [31:0] h_r, h_nxt;
  logic        bad_r;

  // Result queue
  out_item_t            resq_r [RESQ_DEPTH];
  logic [RESQ_AW-1:0]   wptr_r, rptr_r;
  logic [RESQ_AW:0]     cnt_r,  cnt_nxt;
  logic                 res_full, res_push, res_pop;
  out_item_t            res_item;

  logic [31:0] h_base, mul_a, mul_p;

  assign res_full = cnt_r == (RESQ_AW+1)'(RESQ_DEPTH);
  assign empty    = cnt_r == '0;
  assign res_pop  = pop && !empty;
  assign out_item = resq_r[rptr_r];

  // Shared multiplier: fold step or finalize step
  always_comb begin
    h_base = cmd.first ? cmd.init : h_r;
    if (state_r == ST_FIN) begin
      mul_a = h_r ^ (h_r >> FIN_SHIFT_A);
    end else if (cmd.op == OP_TAIL) begin
      mul_a = h_base ^ cmd.opnd;
    end else begin
      mul_a = h_base;
    end
    mul_p = mul_a * MIX_MULT;
  end

  assign res_item.key_hash    = mul_p ^ (mul_p >> FIN_SHIFT_B);
  assign res_item.bad_framing = bad_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        if (!cmdq_stat.empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_FULL: h_nxt = mul_p ^ cmd.opnd;
            OP_TAIL: h_nxt = mul_p;
            default: h_nxt = h_base;
          endcase
          if (cmd.last) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      default: state_nxt = ST_EXEC;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push && !res_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (res_pop && !res_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EXEC;
      wptr_r  <= '0;
      rptr_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (res_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (res_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  // Hash, verdict and result storage
  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    if (cmd_pop && cmd.last) begin
      bad_r <= cmd.bad;
    end
    if (res_push) begin
      resq_r[wptr_r] <= res_item;
    end
  end

endmodule
